>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms on clk; NOW and NEXT held off by rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define FWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after reset
`define FWC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/fwc_pkg.sv
// ----------------------------------------------------------------------------
// fwc_pkg
// types, codes and constants shared by the frenet to cartesian converter
// ----------------------------------------------------------------------------
package fwc_pkg;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam int COUNT_W      = 9;
  localparam int SLOT_LIMIT   = 256;
  localparam int CORDIC_STEPS = 32;
  localparam int NORM_LOW     = 40;
  localparam int ROUND_SHIFT  = 16;
  localparam int XW           = 44;  // heading vector width
  localparam int UW           = 50;  // rotated offset vector width
  localparam int DW           = 33;  // segment vector and raw offset width

  localparam logic [31:0] KINV = 32'h9B74_EDA8;
  localparam logic signed [XW-1:0] NORM_TOP = XW'(64'sd1 <<< NORM_LOW);
  localparam logic signed [UW-1:0] SAT_HI = UW'(64'sd2147483647);
  localparam logic signed [UW-1:0] SAT_LO = UW'(-64'sd2147483648);
  localparam logic signed [UW-1:0] HALF_LSB = UW'(64'sd32768);

  typedef struct packed {
    logic               command;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic [30:0]        entry_arc;
    logic [30:0]        query_arc;
    logic signed [31:0] query_offset;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         segment_start;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        arc;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
  } cordic_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
  } cordic_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_SETUP, ST_MUL_U, ST_MUL_V, ST_MUL_END, ST_ROT, ST_FIN
  } fwc_state_t;

  typedef enum logic [1:0] {
    CS_IDLE, CS_NORM, CS_ROT
  } fwc_cstate_t;

  function automatic logic signed [31:0] sat32(input logic signed [UW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/fwc_table.sv
// ----------------------------------------------------------------------------
// fwc_table
// waypoint table, one write port and one registered read port
// ----------------------------------------------------------------------------
module fwc_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  fwc_pkg::entry_t  wr_data,
  input  logic [AW-1:0]    rd_addr,
  output fwc_pkg::entry_t  rd_data
);
  import fwc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/fwc_cordic.sv
// ----------------------------------------------------------------------------
// fwc_cordic
// normalizes the segment vector, then runs vectoring steps on it while the
// offset vector is turned by the opposite micro-rotations
// ----------------------------------------------------------------------------
module fwc_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  fwc_pkg::cordic_cmd_t cmd,
  output fwc_pkg::cordic_sts_t sts
);
  import fwc_pkg::*;

  fwc_cstate_t state, state_next;
  logic signed [XW-1:0] x, y;
  logic signed [UW-1:0] u, v;
  logic [4:0] step;
  logic done;
  logic need_shift;
  logic last_step;
  logic dir;

  assign need_shift = (x < NORM_TOP) && (y < NORM_TOP) && (y > -NORM_TOP);
  assign last_step  = (step == 5'(CORDIC_STEPS - 1));
  assign dir        = !y[XW-1];

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: if (cmd.start) state_next = CS_NORM;
      CS_NORM: if (!need_shift) state_next = CS_ROT;
      CS_ROT:  if (last_step) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == CS_ROT) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CS_IDLE: begin
        if (cmd.start) begin
          x    <= XW'(cmd.dx);
          y    <= XW'(cmd.dy);
          u    <= cmd.u;
          v    <= cmd.v;
          step <= '0;
        end
      end
      CS_NORM: begin
        if (need_shift) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      CS_ROT: begin
        // offset vector turns opposite to the vectoring step
        if (dir) begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          u <= u - (v >>> step);
          v <= v + (u >>> step);
        end else begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          u <= u + (v >>> step);
          v <= v - (u >>> step);
        end
        step <= step + 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.done = done;
    sts.u    = u;
    sts.v    = v;
  end

endmodule

>>> sv/frenet_to_cartesian.sv
// ----------------------------------------------------------------------------
// frenet_to_cartesian
// converts frenet points (s, d) to cartesian points over a waypoint table
// ----------------------------------------------------------------------------
// item channel: item_valid/item_ready carry one word. a write word loads one
//   table entry and leaves the block idle. a convert word walks the
//   table and produces one result word.
// result channel: result_valid/result_ready carry point_x, point_y and the
//   index of the segment start waypoint.
// cfg channel: cfg_valid/cfg_ready write waypoint_count, always ready.
// a convert takes one table read per visited entry (up to the active count
//   n), a multiplier pass for each offset component, k normalize shifts (up
//   to 40) and 32 cordic steps; a zero-length segment skips the scaling, the
//   shifts and the steps. one convert is in flight, and the next word can be
//   taken in the cycle after its result is registered.
// result is held in an output register; the block takes new words while it
//   waits, and a convert finishing while the previous result is unread waits
//   in its last stage until the receiver takes it.
// reset empties the output, sets waypoint_count to 2; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module frenet_to_cartesian #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  fwc_pkg::in_word_t                   item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output fwc_pkg::out_word_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fwc_pkg::COUNT_W-1:0]         cfg_data
);
  import fwc_pkg::*;

  localparam int AW    = $clog2(MAX_WAYPOINTS);
  localparam int CW    = AW + 1;
  localparam int LIMIT = (MAX_WAYPOINTS < SLOT_LIMIT) ? MAX_WAYPOINTS : SLOT_LIMIT;

  fwc_state_t state, state_next;

  logic [COUNT_W-1:0] waypoint_count;
  logic [COUNT_W-1:0] active_n;

  logic               item_fire;
  logic               tbl_we;
  logic [AW-1:0]      rd_addr;
  entry_t             rd_data;
  entry_t             wr_data;

  logic [30:0]        q_arc;
  logic signed [31:0] q_off;
  logic [CW-1:0]      cur;
  logic               fetch_nxt;
  logic signed [31:0] e0_x, e0_y;
  logic signed [31:0] prev_x, prev_y;
  logic [30:0]        prev_arc;
  logic [7:0]         seg_idx;
  logic signed [31:0] nxt_x, nxt_y;

  logic               arc_hit, cur_last, walk_done;

  logic signed [DW-1:0] dx0, dy0, dxp, dyp, u0, v0;
  logic                 pos0, neg0;
  logic signed [DW-1:0] dx_r, dy_r, u_raw, v_raw;
  logic                 pre_pos, pre_neg, zero_seg;

  logic signed [DW-1:0] mul_src, mul_abs;
  logic [63:0]          prod;
  logic                 prod_neg;
  logic [63:0]          prod_rnd;
  logic signed [UW-1:0] scaled;
  logic signed [UW-1:0] u_r, v_r, u_pre, v_pre;

  logic signed [UW-1:0] ux, vy, sum_x, sum_y;
  logic                 fin_fire;

  cordic_cmd_t ccmd;
  cordic_sts_t csts;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= COUNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      waypoint_count <= cfg_data;
    end
  end

  always_comb begin
    if (waypoint_count < COUNT_W'(2)) begin
      active_n = COUNT_W'(2);
    end else if (32'(waypoint_count) > LIMIT) begin
      active_n = COUNT_W'(LIMIT);
    end else begin
      active_n = waypoint_count;
    end
  end

  // table
  assign item_fire = item_valid && item_ready;
  assign tbl_we    = item_fire && (item.command == CMD_WRITE) &&
                     (32'(item.entry_index) < MAX_WAYPOINTS);
  assign wr_data   = '{x: item.entry_x, y: item.entry_y, arc: item.entry_arc};

  fwc_table #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (AW'(item.entry_index)),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // walk decisions; data on rd_data belongs to entry cur
  assign arc_hit   = q_arc > rd_data.arc;
  assign cur_last  = (32'(cur) + 1) >= 32'(active_n);
  assign walk_done = fetch_nxt || ((cur != '0) && (!arc_hit || cur_last));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (item_fire && item.command == CMD_CONVERT) state_next = ST_WALK;
      ST_WALK:    if (walk_done) state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_MUL_U;
      ST_MUL_U:   state_next = zero_seg ? ST_FIN : ST_MUL_V;
      ST_MUL_V:   state_next = ST_MUL_END;
      ST_MUL_END: state_next = ST_ROT;
      ST_ROT:     if (csts.done) state_next = ST_FIN;
      ST_FIN:     if (fin_fire) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    rd_addr    = '0;
    ccmd.start = 1'b0;
    unique case (state)
      ST_IDLE:    item_ready = 1'b1;
      ST_WALK:    rd_addr = AW'(cur + CW'(1));
      ST_MUL_END: ccmd.start = 1'b1;
      default: ;
    endcase
  end

  assign fin_fire = (state == ST_FIN) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table walk
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_fire && item.command == CMD_CONVERT) begin
      q_arc     <= item.query_arc;
      q_off     <= item.query_offset;
      cur       <= '0;
      fetch_nxt <= 1'b0;
    end else if (state == ST_WALK) begin
      if (fetch_nxt) begin
        nxt_x <= rd_data.x;
        nxt_y <= rd_data.y;
      end else if (cur == '0) begin
        e0_x      <= rd_data.x;
        e0_y      <= rd_data.y;
        prev_x    <= rd_data.x;
        prev_y    <= rd_data.y;
        prev_arc  <= rd_data.arc;
        seg_idx   <= '0;
        cur       <= CW'(1);
        // query at or before the first arc: entry 1 ends the segment
        fetch_nxt <= !arc_hit;
      end else if (arc_hit) begin
        prev_x   <= rd_data.x;
        prev_y   <= rd_data.y;
        prev_arc <= rd_data.arc;
        seg_idx  <= 8'(cur);
        if (cur_last) begin
          // past the last arc: wrap to entry 0
          nxt_x <= e0_x;
          nxt_y <= e0_y;
        end else begin
          cur <= cur + CW'(1);
        end
      end else begin
        nxt_x <= rd_data.x;
        nxt_y <= rd_data.y;
      end
    end
  end

  // segment vector with a quarter turn into the right half plane
  always_comb begin
    dx0  = DW'(nxt_x) - DW'(prev_x);
    dy0  = DW'(nxt_y) - DW'(prev_y);
    u0   = $signed({2'b00, q_arc}) - $signed({2'b00, prev_arc});
    v0   = -DW'(q_off);
    dxp  = dx0;
    dyp  = dy0;
    pos0 = 1'b0;
    neg0 = 1'b0;
    if (dx0[DW-1]) begin
      if (!dy0[DW-1]) begin
        dxp  = dy0;
        dyp  = -dx0;
        pos0 = 1'b1;
      end else begin
        dxp  = -dy0;
        dyp  = dx0;
        neg0 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      dx_r     <= dxp;
      dy_r     <= dyp;
      pre_pos  <= pos0;
      pre_neg  <= neg0;
      zero_seg <= (dx0 == '0) && (dy0 == '0);
      u_raw    <= u0;
      v_raw    <= v0;
    end
  end

  // 1/K scaling on the magnitude, one shared multiplier
  assign mul_src  = (state == ST_MUL_U) ? u_raw : v_raw;
  assign mul_abs  = mul_src[DW-1] ? -mul_src : mul_src;
  assign prod_rnd = (prod + 64'd32768) >> ROUND_SHIFT;
  assign scaled   = prod_neg ? -$signed({2'b00, prod_rnd[47:0]})
                             :  $signed({2'b00, prod_rnd[47:0]});

  always_comb begin
    u_pre = u_r;
    v_pre = scaled;
    if (pre_pos) begin
      u_pre = -scaled;
      v_pre = u_r;
    end else if (pre_neg) begin
      u_pre = scaled;
      v_pre = -u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL_U || state == ST_MUL_V) begin
      prod     <= 64'(mul_abs[31:0]) * 64'(KINV);
      prod_neg <= mul_src[DW-1];
    end
    if (state == ST_MUL_U && zero_seg) begin
      // zero-length segment: heading taken as 0
      u_r <= UW'(u_raw) <<< ROUND_SHIFT;
      v_r <= UW'(v_raw) <<< ROUND_SHIFT;
    end else if (state == ST_MUL_V) begin
      u_r <= scaled;
    end else if (state == ST_ROT && csts.done) begin
      u_r <= csts.u;
      v_r <= csts.v;
    end
  end

  always_comb begin
    ccmd.dx = dx_r;
    ccmd.dy = dy_r;
    ccmd.u  = u_pre;
    ccmd.v  = v_pre;
  end

  fwc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .cmd (ccmd),
    .sts (csts)
  );

  // round back to q16.16, add start waypoint, saturate
  assign ux    = (u_r + HALF_LSB) >>> ROUND_SHIFT;
  assign vy    = (v_r + HALF_LSB) >>> ROUND_SHIFT;
  assign sum_x = UW'(prev_x) + ux;
  assign sum_y = UW'(prev_y) + vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      result.point_x       <= sat32(sum_x);
      result.point_y       <= sat32(sum_y);
      result.segment_start <= seg_idx;
    end
  end

endmodule

>>> sv/fwc_checker.sv
// ----------------------------------------------------------------------------
// fwc_checker
// port level checks for the frenet to cartesian converter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwc_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input fwc_pkg::in_word_t  item,
  input logic               result_valid,
  input logic               result_ready,
  input fwc_pkg::out_word_t result
);
  import fwc_pkg::*;

  // a pending result word stays put until taken
  `FWC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

  // after reset the block is empty and takes words
  `FWC_ASSERT_RST(a_reset_state, !result_valid && item_ready)

  // a convert word keeps the block busy
  `FWC_ASSERT_NEXT(a_convert_busy, item_valid && item_ready && item.command == CMD_CONVERT, !item_ready)

  // a new result only comes out of a convert in progress
  `FWC_ASSERT_NOW(a_result_source, $rose(result_valid), $past(!item_ready))

endmodule

bind frenet_to_cartesian fwc_checker u_fwc_checker (.*);

>>> sim/frenet_to_cartesian_tb.sv
// ----------------------------------------------------------------------------
// frenet_to_cartesian_tb
// drives waypoint loads and frenet queries through the converter, predicts
// every result word with a bit-exact fixed point cordic model of its own and
// checks the words in order; sender bursts, receiver stalls and one long
// receiver hold-off exercise the handshakes, and waypoint_count is swept
// across several phases including out-of-range values
// ----------------------------------------------------------------------------
class conv_scoreboard;
  logic [31:0] wp_x[256];
  logic [31:0] wp_y[256];
  logic [30:0] wp_arc[256];
  logic [8:0]  count;
  fwc_pkg::out_word_t pending[$];
  int errors;

  function new();
    count  = 2;
    errors = 0;
    foreach (wp_arc[k]) begin
      wp_x[k]   = '0;
      wp_y[k]   = '0;
      wp_arc[k] = '0;
    end
  endfunction

  function int active_count();
    int n;
    n = count;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    return n;
  endfunction

  function longint kscale(longint v);
    longint unsigned m, p;
    m = (v < 0) ? -v : v;
    p = (m * {32'b0, fwc_pkg::KINV} + 64'd32768) >> 16;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function fwc_pkg::out_word_t convert(fwc_pkg::in_word_t w);
    int n, prev, nxt, sh, pre, i;
    longint xp, yp, dx, dy, u, v, t, nx, ny;
    longint unsigned ax, ay, mag;
    logic [31:0] dirs;
    fwc_pkg::out_word_t r;
    n = active_count();
    prev = 0;
    pre = 0;
    dirs = '0;
    if (w.query_arc > wp_arc[0]) begin
      while (prev + 1 < n && w.query_arc > wp_arc[prev+1]) prev++;
    end
    nxt = (prev + 1 >= n) ? 0 : prev + 1;
    xp = $signed(wp_x[prev]);
    yp = $signed(wp_y[prev]);
    dx = longint'($signed(wp_x[nxt])) - xp;
    dy = longint'($signed(wp_y[nxt])) - yp;
    u = longint'(w.query_arc) - longint'(wp_arc[prev]);
    v = -longint'(w.query_offset);
    if (dx == 0 && dy == 0) begin
      u = u * 65536;
      v = v * 65536;
    end else begin
      // exact quarter turn into the right half plane
      if (dx < 0) begin
        if (dy >= 0) begin
          t = dx; dx = dy; dy = -t; pre = 1;
        end else begin
          t = dx; dx = -dy; dy = t; pre = -1;
        end
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      mag = (ax > ay) ? ax : ay;
      sh = 0;
      while (mag < (64'd1 << 40)) begin
        mag = mag << 1;
        sh++;
      end
      dx = dx <<< sh;
      dy = dy <<< sh;
      for (i = 0; i < 32; i++) begin
        if (dy >= 0) begin
          nx = dx + (dy >>> i); ny = dy - (dx >>> i);
          dirs[i] = 1'b1;
        end else begin
          nx = dx - (dy >>> i); ny = dy + (dx >>> i);
        end
        dx = nx; dy = ny;
      end
      u = kscale(u);
      v = kscale(v);
      if (pre == 1) begin
        t = u; u = -v; v = t;
      end else if (pre == -1) begin
        t = u; u = v; v = -t;
      end
      // replay the heading steps in order with opposite turns to rotate by +heading
      for (i = 0; i < 32; i++) begin
        if (dirs[i]) begin
          nx = u - (v >>> i); ny = v + (u >>> i);
        end else begin
          nx = u + (v >>> i); ny = v - (u >>> i);
        end
        u = nx; v = ny;
      end
    end
    r.point_x = 32'(clip32(xp + ((u + 32768) >>> 16)));
    r.point_y = 32'(clip32(yp + ((v + 32768) >>> 16)));
    r.segment_start = 8'(prev);
    return r;
  endfunction

  function void note_item(fwc_pkg::in_word_t w);
    if (w.command == fwc_pkg::CMD_WRITE) begin
      wp_x[w.entry_index]   = w.entry_x;
      wp_y[w.entry_index]   = w.entry_y;
      wp_arc[w.entry_index] = w.entry_arc;
    end else begin
      pending.insert(pending.size(), convert(w));
    end
  endfunction

  function void check_result(fwc_pkg::out_word_t r);
    fwc_pkg::out_word_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word x=%h y=%h seg=%0d",
                                 r.point_x, r.point_y, r.segment_start);
      return;
    end
    e = pending.pop_front();
    if (r.point_x !== e.point_x || r.point_y !== e.point_y ||
        r.segment_start !== e.segment_start) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp x=%h y=%h seg=%0d, got x=%h y=%h seg=%0d",
                 e.point_x, e.point_y, e.segment_start,
                 r.point_x, r.point_y, r.segment_start);
    end
  endfunction
endclass

module frenet_to_cartesian_tb;
  import fwc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 400;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_word_t item;
  logic result_valid;
  logic result_ready;
  out_word_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  conv_scoreboard sb = new();

  int burst_left;
  int accepted_items;
  int idle_cycles;
  int hold_cnt;
  bit hold_done;
  int stall_mode;
  int mode_left;

  frenet_to_cartesian u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // input-side bookkeeping and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (item_valid && item_ready) begin
        sb.note_item(item);
        accepted_items <= accepted_items + 1;
      end
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // receiver with its own stall pattern and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) sb.check_result(result);
      if (!hold_done && accepted_items >= 400) begin
        hold_done = 1;
        hold_cnt  = 1500;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: result_ready <= 1'b1;
          1: result_ready <= $urandom_range(0, 1);
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic load_entry(int idx, logic [31:0] x, logic [31:0] y, logic [30:0] a);
    in_word_t w;
    w.command      = CMD_WRITE;
    w.entry_index  = idx[7:0];
    w.entry_x      = x;
    w.entry_y      = y;
    w.entry_arc    = a;
    w.query_arc    = 31'($urandom);
    w.query_offset = $urandom;
    send_word(w);
  endtask

  task automatic query(logic [30:0] s, logic [31:0] d);
    in_word_t w;
    w.command      = CMD_CONVERT;
    w.entry_index  = 8'($urandom);
    w.entry_x      = $urandom;
    w.entry_y      = $urandom;
    w.entry_arc    = 31'($urandom);
    w.query_arc    = s;
    w.query_offset = d;
    send_word(w);
  endtask

  // block is idle before a register write
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [8:0] c);
    cfg_data  <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.count = c;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 19))
      0, 1: return $urandom;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
    endcase
  endfunction

  task automatic run_phase(logic [8:0] c, int n_rand);
    int n, k;
    longint a, s;
    logic [31:0] x, y;
    drain();
    write_count(c);
    n = sb.active_count();
    // well-formed track: non-decreasing arcs, mostly a random walk in x/y
    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h4000_0000) : $urandom_range(0, 4096);
    x = rand_coord();
    y = rand_coord();
    for (k = 0; k < n; k++) begin
      load_entry(k, x, y, a[30:0]);
      a = a + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32'h0010_0000));
      case ($urandom_range(0, 9))
        0: ;  // repeated point, zero-length segment
        1: begin x = rand_coord(); y = rand_coord(); end
        default: begin
          x = x + 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
          y = y + 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        end
      endcase
    end
    for (int j = 0; j < n_rand; j++) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
          0: s = sb.wp_arc[k];
          1: s = longint'(sb.wp_arc[k]) + $urandom_range(1, 32'h0001_0000);
          2: s = longint'(sb.wp_arc[k]) - $urandom_range(1, 32'h0001_0000);
          3: s = $urandom & 32'h7FFF_FFFF;
          4: s = 0;
          default: s = 32'h7FFF_FFFF;
        endcase
        if (s < 0) s = 0;
        if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
        query(s[30:0], rand_offset());
      end else begin
        // noise: overwrite a random slot with random content
        load_entry($urandom_range(0, 255), rand_coord(), rand_coord(),
                   ($urandom_range(0, 1)) ? 31'($urandom) : sb.wp_arc[$urandom_range(0, 255)]);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    accepted_items = 0;
    hold_cnt = 0;
    hold_done = 0;
    stall_mode = 0;
    mode_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two waypoints at reset count
    load_entry(0, 32'd0, 32'd0, 31'd0);
    load_entry(1, 32'd655360, 32'd0, 31'd655360);
    query(31'd0, 32'd0);
    query(31'd327680, 32'd65536);
    query(31'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(31'd100, 32'h8000_0000);
    // zero-length segment
    load_entry(1, 32'd0, 32'd0, 31'd655360);
    query(31'd200000, -32'sd5000);
    // saturating corners, heading in the left half plane
    load_entry(0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1000);
    load_entry(1, 32'h7FFF_FF9B, 32'h8000_0032, 31'd5000);
    query(31'd0, -32'sd1000);
    query(31'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_entry(1, 32'h8000_0000, 32'h7FFF_FFFF, 31'd5000);
    query(31'd3000, 32'd123456);
    load_entry(1, 32'h7FFF_FF9B, 32'h8000_0000, 31'd5000);
    query(31'd3000, 32'h8000_0000);
    load_entry(0, 32'd1000, 32'd1000, 31'd0);
    load_entry(1, -32'sd1000, -32'sd2000, 31'h7FFF_FFFF);
    query(31'd50000, 32'd0);
    query(31'h7FFF_FFFF, -32'sd77777);
    load_entry(255, $urandom, $urandom, 31'($urandom));

    run_phase(9'd3, 40);
    run_phase(9'd0, 30);
    run_phase(9'd8, 40);
    run_phase(9'd1, 30);
    run_phase(9'd511, 60);
    run_phase(9'd16, 40);
    run_phase(9'd5, 40);
    run_phase(9'd64, 60);
    run_phase(9'd2, 40);
    run_phase(9'd33, 50);

    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
